>>> rtl/i2crrs_pkg.sv
package i2crrs_pkg;

  // Largest number of data bytes one transaction reads; larger counts saturate.
  localparam logic [4:0] MaxRead = 5'd16;

  // Read bit that is set in the device address byte for the read phase.
  localparam logic [7:0] ReadBit = 8'h01;

  // Request opcodes.
  localparam logic [1:0] OpPoll   = 2'd0;
  localparam logic [1:0] OpRead   = 2'd1;
  localparam logic [1:0] OpFinish = 2'd2;

  // Bus actions handed to the byte engine.
  localparam logic [2:0] ActNone       = 3'd0;
  localparam logic [2:0] ActStartSend  = 3'd1;
  localparam logic [2:0] ActSend       = 3'd2;
  localparam logic [2:0] ActRstartSend = 3'd3;
  localparam logic [2:0] ActRecvAck    = 3'd4;
  localparam logic [2:0] ActRecvNack   = 3'd5;

  // Sequence phases.
  typedef logic [2:0] phase_t;
  localparam phase_t PhIdle     = 3'd0;
  localparam phase_t PhWaitDevW = 3'd1;
  localparam phase_t PhWaitReg  = 3'd2;
  localparam phase_t PhWaitDevR = 3'd3;
  localparam phase_t PhWaitData = 3'd4;

  typedef struct packed {
    phase_t     phase;
    logic [4:0] bytes_done;
  } seq_state_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       send_stop;
    logic [7:0] read_data;
    logic       data_valid;
    logic       last_byte;
    logic       done_res;
    logic       busy_res;
  } result_t;

endpackage

>>> rtl/i2c_register_read_sequencer.sv
// I2C register read sequencer. Each request is a poll, a read request or a
// transfer-finished event from a byte-level I2C master engine, and each request
// yields exactly one result telling the engine what to do next: start plus the
// device address, the register address, a repeated start with the read bit set,
// and then one receive per data byte, the last with NACK and a stop. A request
// is registered on entry, passes through the sequence logic and lands in the
// result register; one request is taken every cycle while the output side
// keeps up. The result register and the input register each hold one request,
// so a stalled result still lets one more request in. Configuration is written
// through the APB port at byte addresses 0 (device address), 4 (register
// address) and 8 (read count, saturating at 16); write it only while idle.
module i2c_register_read_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] rx_byte_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] bus_action_o,
  output logic [7:0] tx_byte_o,
  output logic       send_stop_o,
  output logic [7:0] read_data_o,
  output logic       data_valid_o,
  output logic       last_byte_o,
  output logic       done_res_o,
  output logic       busy_res_o
);

  localparam logic [1:0] RegDevAddr = 2'd0;
  localparam logic [1:0] RegRegAddr = 2'd1;
  localparam logic [1:0] RegCount   = 2'd2;

  // Configuration registers.
  logic [7:0] dev_addr_q;
  logic [7:0] reg_addr_q;
  logic [4:0] count_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
      reg_addr_q <= '0;
      count_q    <= 5'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegDevAddr: dev_addr_q <= pwdata[7:0];
        RegRegAddr: reg_addr_q <= pwdata[7:0];
        RegCount:   count_q    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegDevAddr: prdata = {24'd0, dev_addr_q};
      RegRegAddr: prdata = {24'd0, reg_addr_q};
      RegCount:   prdata = {27'd0, count_q};
      default:    prdata = '0;
    endcase
  end

  // Input register, result register and sequence state.
  logic                   in_vld_q;
  logic [1:0]             op_q;
  logic [7:0]             rx_q;
  logic                   out_vld_q;
  i2crrs_pkg::result_t    res_q;
  i2crrs_pkg::result_t    res_d;
  i2crrs_pkg::seq_state_t state_q;
  i2crrs_pkg::seq_state_t state_d;
  logic                   out_free;
  logic                   advance;
  logic                   in_take;

  // The result register frees up when empty or when its result leaves now.
  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign advance    = in_vld_q & out_free;
  assign in_stall_o = in_vld_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  i2crrs_step u_step (
    .state_i           (state_q),
    .opcode_i          (op_q),
    .rx_byte_i         (rx_q),
    .device_address_i  (dev_addr_q),
    .register_address_i(reg_addr_q),
    .read_count_i      (count_q),
    .state_o           (state_d),
    .result_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{phase: i2crrs_pkg::PhIdle, bytes_done: 5'd0};
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q <= opcode_i;
      rx_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign bus_action_o = res_q.bus_action;
  assign tx_byte_o    = res_q.tx_byte;
  assign send_stop_o  = res_q.send_stop;
  assign read_data_o  = res_q.read_data;
  assign data_valid_o = res_q.data_valid;
  assign last_byte_o  = res_q.last_byte;
  assign done_res_o   = res_q.done_res;
  assign busy_res_o   = res_q.busy_res;

endmodule

>>> rtl/i2crrs_step.sv
// Next-state and result logic of the register read sequence for one request.
module i2crrs_step (
  input  i2crrs_pkg::seq_state_t state_i,
  input  logic [1:0]             opcode_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [7:0]             device_address_i,
  input  logic [7:0]             register_address_i,
  input  logic [4:0]             read_count_i,
  output i2crrs_pkg::seq_state_t state_o,
  output i2crrs_pkg::result_t    result_o
);

  logic [4:0] count;
  logic [5:0] n;
  logic [5:0] n_next;
  logic       fin;

  assign count  = (read_count_i > i2crrs_pkg::MaxRead) ? i2crrs_pkg::MaxRead : read_count_i;
  assign n      = {1'b0, state_i.bytes_done} + 6'd1;
  assign n_next = n + 6'd1;
  assign fin    = (opcode_i == i2crrs_pkg::OpFinish);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.bus_action = i2crrs_pkg::ActNone;
    case (state_i.phase)
      i2crrs_pkg::PhWaitDevW: begin
        if (fin) begin
          result_o.bus_action = i2crrs_pkg::ActSend;
          result_o.tx_byte    = register_address_i;
          state_o.phase       = i2crrs_pkg::PhWaitReg;
        end
      end
      i2crrs_pkg::PhWaitReg: begin
        if (fin) begin
          result_o.bus_action = i2crrs_pkg::ActRstartSend;
          result_o.tx_byte    = device_address_i | i2crrs_pkg::ReadBit;
          state_o.phase       = i2crrs_pkg::PhWaitDevR;
        end
      end
      i2crrs_pkg::PhWaitDevR: begin
        if (fin) begin
          state_o.bytes_done = '0;
          if (count == 5'd0) begin
            // Nothing to read: close the bus right after the address phase.
            result_o.send_stop = 1'b1;
            result_o.done_res  = 1'b1;
            state_o.phase      = i2crrs_pkg::PhIdle;
          end else begin
            result_o.bus_action = (count == 5'd1) ? i2crrs_pkg::ActRecvNack
                                                  : i2crrs_pkg::ActRecvAck;
            state_o.phase       = i2crrs_pkg::PhWaitData;
          end
        end
      end
      i2crrs_pkg::PhWaitData: begin
        if (fin) begin
          result_o.read_data  = rx_byte_i;
          result_o.data_valid = 1'b1;
          if (n >= {1'b0, count}) begin
            result_o.last_byte = 1'b1;
            result_o.send_stop = 1'b1;
            result_o.done_res  = 1'b1;
            state_o.bytes_done = '0;
            state_o.phase      = i2crrs_pkg::PhIdle;
          end else begin
            state_o.bytes_done  = n[4:0];
            result_o.bus_action = (n_next >= {1'b0, count}) ? i2crrs_pkg::ActRecvNack
                                                            : i2crrs_pkg::ActRecvAck;
          end
        end
      end
      default: begin
        // Idle, and any code that is not a phase.
        state_o.phase = i2crrs_pkg::PhIdle;
        if (opcode_i == i2crrs_pkg::OpRead) begin
          result_o.bus_action = i2crrs_pkg::ActStartSend;
          result_o.tx_byte    = device_address_i;
          state_o.bytes_done  = '0;
          state_o.phase       = i2crrs_pkg::PhWaitDevW;
        end
      end
    endcase
    result_o.busy_res = (state_o.phase != i2crrs_pkg::PhIdle);
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import i2crrs_pkg::*;

  // Opcode 3 has no name in the package; the block treats it as a poll.
  localparam logic [1:0] OpSpare = 2'd3;

  // Byte addresses of the configuration registers.
  localparam logic [3:0] RegDevice  = 4'd0;
  localparam logic [3:0] RegAddress = 4'd4;
  localparam logic [3:0] RegCount   = 4'd8;

  // Requests sent in total before the random part stops, and the window of
  // requests doing real work (a read from idle, a finish while busy) in which
  // neither side idles.
  localparam int ItemTarget = 450;
  localparam int CalmFirst  = 150;
  localparam int CalmLast   = 250;
  localparam int CycleLimit = 200000;

  typedef enum logic {RowRequest, RowConfig} row_kind_e;

  // One row of the directed table. A row either writes a register or sends a
  // request; a request row may carry a hand-written expected result.
  typedef struct {
    row_kind_e   kind;
    logic [1:0]  op;
    logic [7:0]  rx;
    logic [3:0]  addr;
    logic [31:0] wdata;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  bus_action_o;
  logic [7:0]  tx_byte_o;
  logic        send_stop_o;
  logic [7:0]  read_data_o;
  logic        data_valid_o;
  logic        last_byte_o;
  logic        done_res_o;
  logic        busy_res_o;

  i2c_register_read_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bus_action_o(bus_action_o),
    .tx_byte_o   (tx_byte_o),
    .send_stop_o (send_stop_o),
    .read_data_o (read_data_o),
    .data_valid_o(data_valid_o),
    .last_byte_o (last_byte_o),
    .done_res_o  (done_res_o),
    .busy_res_o  (busy_res_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Our own copy of the sequencer: register values and sequence state.
  logic [7:0] cfg_device;
  logic [7:0] cfg_register;
  logic [4:0] cfg_count;
  phase_t     seq_phase;
  logic [4:0] seq_bytes_done;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];

  int  mismatches;
  int  requests_sent;
  int  work_requests;
  int  register_writes;
  int  transactions_done;
  int  bytes_delivered;
  int  cycles;
  bit  calm;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Advances the sequence by one request and returns the result the block owes
  // for it. The read count saturates at MaxRead and is read fresh at every step,
  // so a count written mid-transaction takes effect on the next byte.
  function automatic result_t sequence_step(logic [1:0] op, logic [7:0] rx);
    result_t    res;
    logic [4:0] limit;
    int         next_count;
    res = '0;
    limit = (cfg_count > MaxRead) ? MaxRead : cfg_count;
    case (seq_phase)
      PhWaitDevW: begin
        if (op == OpFinish) begin
          res.bus_action = ActSend;
          res.tx_byte = cfg_register;
          seq_phase = PhWaitReg;
        end
      end
      PhWaitReg: begin
        if (op == OpFinish) begin
          res.bus_action = ActRstartSend;
          res.tx_byte = cfg_device | ReadBit;
          seq_phase = PhWaitDevR;
        end
      end
      PhWaitDevR: begin
        if (op == OpFinish) begin
          seq_bytes_done = '0;
          if (limit == 0) begin
            // Nothing to read: stop right after the address phase.
            res.send_stop = 1'b1;
            res.done_res = 1'b1;
            seq_phase = PhIdle;
          end else begin
            res.bus_action = (limit == 1) ? ActRecvNack : ActRecvAck;
            seq_phase = PhWaitData;
          end
        end
      end
      PhWaitData: begin
        if (op == OpFinish) begin
          next_count = int'(seq_bytes_done) + 1;
          res.read_data = rx;
          res.data_valid = 1'b1;
          if (next_count >= int'(limit)) begin
            res.last_byte = 1'b1;
            res.send_stop = 1'b1;
            res.done_res = 1'b1;
            seq_bytes_done = '0;
            seq_phase = PhIdle;
          end else begin
            seq_bytes_done = next_count[4:0];
            res.bus_action = (next_count + 1 >= int'(limit)) ? ActRecvNack : ActRecvAck;
          end
        end
      end
      default: begin
        // Idle: only a read request starts a transaction.
        seq_phase = PhIdle;
        if (op == OpRead) begin
          res.bus_action = ActStartSend;
          res.tx_byte = cfg_device;
          seq_bytes_done = '0;
          seq_phase = PhWaitDevW;
        end
      end
    endcase
    res.busy_res = (seq_phase != PhIdle);
    return res;
  endfunction

  // Sends one request and waits until the block takes it. The expectation is
  // computed at acceptance, so the queue is in the order the block sees. The
  // caller must drive again in the same time step, since valid stays high.
  // Outside the calm window, about 16 in 100 of the requests are followed by a
  // pause of random length with valid low.
  task automatic send_request(logic [1:0] op, logic [7:0] rx, bit typed, result_t want);
    result_t predicted;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (in_stall_o);
    if ((op == OpRead && seq_phase == PhIdle) || (op == OpFinish && seq_phase != PhIdle))
      work_requests++;
    requests_sent++;
    predicted = sequence_step(op, rx);
    pending_results.push_back(typed ? want : predicted);
    calm = (work_requests >= CalmFirst) && (work_requests < CalmLast);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Writes one register once every owed result has come back. Each request
  // yields a result, so an empty queue plus a short settle means no request
  // is left inside the block.
  task automatic write_register(logic [3:0] addr, logic [31:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      RegDevice:  cfg_device = value[7:0];
      RegAddress: cfg_register = value[7:0];
      RegCount:   cfg_count = value[4:0];
      default:    ;
    endcase
    register_writes++;
    @(posedge clk_i);
  endtask

  function automatic stim_row_t request_row(logic [1:0] op, logic [7:0] rx);
    stim_row_t row;
    row = '{kind: RowRequest, op: op, rx: rx, addr: '0, wdata: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t checked_row(logic [1:0] op, logic [7:0] rx, result_t want);
    stim_row_t row;
    row = request_row(op, rx);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t config_row(logic [3:0] addr, logic [31:0] value);
    stim_row_t row;
    row = '{kind: RowConfig, op: OpPoll, rx: '0, addr: addr, wdata: value, typed: 1'b0,
            want: '0};
    return row;
  endfunction

  // Mostly short reads; now and then a count at or past the saturation point.
  function automatic logic [31:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(0, 4);
    if (pick < 85) return $urandom_range(5, 16);
    return $urandom_range(17, 31);
  endfunction

  function automatic logic [31:0] random_byte();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return 32'h00;
    if (pick == 1) return 32'hFF;
    return $urandom_range(0, 255);
  endfunction

  // The result side stalls at random with odds of about 29 in 100, except in the calm window.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 29);
  end

  // Every accepted result is checked field by field against the oldest
  // expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected (bus_action)", bus_action_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (bus_action_o !== want.bus_action)
          report_mismatch("bus_action", bus_action_o, want.bus_action);
        if (tx_byte_o !== want.tx_byte) report_mismatch("tx_byte", tx_byte_o, want.tx_byte);
        if (send_stop_o !== want.send_stop)
          report_mismatch("send_stop", send_stop_o, want.send_stop);
        if (read_data_o !== want.read_data)
          report_mismatch("read_data", read_data_o, want.read_data);
        if (data_valid_o !== want.data_valid)
          report_mismatch("data_valid", data_valid_o, want.data_valid);
        if (last_byte_o !== want.last_byte)
          report_mismatch("last_byte", last_byte_o, want.last_byte);
        if (done_res_o !== want.done_res)
          report_mismatch("done_res", done_res_o, want.done_res);
        if (busy_res_o !== want.busy_res)
          report_mismatch("busy_res", busy_res_o, want.busy_res);
        if (want.done_res) transactions_done++;
        if (want.data_valid) bytes_delivered++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("i2c_register_read_sequencer regression: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t directed[$];
    logic [1:0] op;
    int         pick;
    int         noise;

    requests_sent = 0;
    work_requests = 0;
    register_writes = 0;
    calm = 1'b0;
    cfg_device = 8'h00;
    cfg_register = 8'h00;
    cfg_count = 5'd1;
    seq_phase = PhIdle;
    seq_bytes_done = '0;

    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    opcode_i    <= OpPoll;
    rx_byte_i   <= '0;

    // Directed part. Right after reset the device address and register
    // address are zero and one byte is read.
    // Idle requests: a poll, a stray finish, and the spare opcode all do nothing.
    directed.push_back(checked_row(OpPoll, 8'h00, {ActNone, 8'h00, 1'b0, 8'h00, 4'b0}));
    directed.push_back(checked_row(OpFinish, 8'hFF, {ActNone, 8'h00, 1'b0, 8'h00, 4'b0}));
    directed.push_back(checked_row(OpSpare, 8'hA5, {ActNone, 8'h00, 1'b0, 8'h00, 4'b0}));
    // A one-byte read with the reset settings; a second read request while
    // busy is ignored and a poll in the data phase changes nothing.
    directed.push_back(checked_row(OpRead, 8'h00,
                                   {ActStartSend, 8'h00, 1'b0, 8'h00, 4'b0001}));
    directed.push_back(request_row(OpRead, 8'h00));
    directed.push_back(request_row(OpFinish, 8'h00));
    directed.push_back(request_row(OpFinish, 8'h00));
    directed.push_back(request_row(OpFinish, 8'h00));
    directed.push_back(request_row(OpPoll, 8'h00));
    directed.push_back(checked_row(OpFinish, 8'hFF,
                                   {ActNone, 8'h00, 1'b1, 8'hFF, 4'b1110}));
    // All-ones addresses and a zero count: the read stops after the address phase.
    directed.push_back(config_row(RegDevice, 32'hFF));
    directed.push_back(config_row(RegAddress, 32'hFF));
    directed.push_back(config_row(RegCount, 32'h0));
    directed.push_back(checked_row(OpRead, 8'h00,
                                   {ActStartSend, 8'hFF, 1'b0, 8'h00, 4'b0001}));
    directed.push_back(checked_row(OpFinish, 8'h00,
                                   {ActSend, 8'hFF, 1'b0, 8'h00, 4'b0001}));
    directed.push_back(checked_row(OpFinish, 8'h00,
                                   {ActRstartSend, 8'hFF, 1'b0, 8'h00, 4'b0001}));
    directed.push_back(checked_row(OpFinish, 8'h00,
                                   {ActNone, 8'h00, 1'b1, 8'h00, 4'b0010}));
    // A three-byte read whose count drops to one after the first data byte,
    // so the second byte already closes the transaction.
    directed.push_back(config_row(RegDevice, 32'h5A));
    directed.push_back(config_row(RegAddress, 32'hC3));
    directed.push_back(config_row(RegCount, 32'd3));
    directed.push_back(request_row(OpRead, 8'h00));
    directed.push_back(request_row(OpFinish, 8'h00));
    directed.push_back(request_row(OpFinish, 8'h00));
    directed.push_back(request_row(OpFinish, 8'h00));
    directed.push_back(request_row(OpFinish, 8'h80));
    directed.push_back(config_row(RegCount, 32'd1));
    directed.push_back(request_row(OpFinish, 8'h7F));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == RowConfig) begin
        write_register(directed[i].addr, directed[i].wdata);
      end else begin
        send_request(directed[i].op, directed[i].rx, directed[i].typed, directed[i].want);
      end
    end

    // Random part: mostly complete register reads with random content, with
    // polls, ignored read requests, spare opcodes and stray finishes mixed in,
    // and now and then a new count written in the middle of a transaction.
    while (requests_sent < ItemTarget) begin
      if ($urandom_range(3) == 0) begin
        write_register(RegDevice, random_byte());
        write_register(RegAddress, random_byte());
        write_register(RegCount, random_count());
      end
      noise = $urandom_range(0, 2);
      repeat (noise) begin
        pick = $urandom_range(2);
        op = (pick == 0) ? OpPoll : (pick == 1) ? OpFinish : OpSpare;
        send_request(op, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      send_request(OpRead, 8'($urandom_range(0, 255)), 1'b0, '0);
      while (seq_phase != PhIdle) begin
        pick = $urandom_range(99);
        if (pick < 72) op = OpFinish;
        else if (pick < 84) op = OpPoll;
        else if (pick < 92) op = OpRead;
        else if (pick < 97) op = OpSpare;
        else begin
          write_register(RegCount, random_count());
          op = OpFinish;
        end
        send_request(op, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    // Drain: every owed result must come back, then a few idle cycles to
    // catch anything extra the block might still emit.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests (%0d doing work) with %0d register writes.", requests_sent,
             work_requests, register_writes);
    $display("Checked %0d finished transactions and %0d delivered data bytes.",
             transactions_done, bytes_delivered);
    if (mismatches == 0) begin
      $display("i2c_register_read_sequencer regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("i2c_register_read_sequencer regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/i2crrs_pkg.sv
rtl/i2crrs_step.sv
rtl/i2c_register_read_sequencer.sv
verif/tb.sv
